### rtl/core/jsu_pkg.sv
package jsu_pkg;

  // Decoder state, one-hot
  typedef enum logic [6:0] {
    M_NORMAL        = 7'b0000001,
    M_ESCAPE        = 7'b0000010,
    M_HEX_FIRST     = 7'b0000100,
    M_AFTER_HIGH    = 7'b0001000,
    M_AFTER_HIGH_BS = 7'b0010000,
    M_HEX_SECOND    = 7'b0100000,
    M_RAW           = 7'b1000000
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_MISSING_QUOTE = 3'd1,
    ST_BAD_CHAR      = 3'd2,
    ST_BAD_ESCAPE    = 3'd3,
    ST_BAD_HEX       = 3'd4,
    ST_BAD_SURROGATE = 3'd5
  } status_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_U   = 8'h75;

  // top six bits of a high / low surrogate code unit
  localparam logic [5:0]  SURR_HI_TAG    = 6'h36;
  localparam logic [5:0]  SURR_LO_TAG    = 6'h37;
  // 0x10000 >> 10
  localparam logic [10:0] SURR_PAIR_BASE = 11'h040;

  typedef struct packed {
    logic [2:0]      count;
    logic [3:0][7:0] data;
  } utf8_t;

  // result of one byte in normal or escape state
  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic       done;
    status_t    st;
    mode_t      mode;
    logic [1:0] raw;
    logic       start_hex;
  } step_t;

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t r;
    r = '0;
    if (cp <= 21'h00007F) begin
      r.count   = 3'd1;
      r.data[0] = cp[7:0];
    end else if (cp <= 21'h0007FF) begin
      r.count   = 3'd2;
      r.data[0] = {3'b110, cp[10:6]};
      r.data[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'h00FFFF) begin
      r.count   = 3'd3;
      r.data[0] = {4'b1110, cp[15:12]};
      r.data[1] = {2'b10, cp[11:6]};
      r.data[2] = {2'b10, cp[5:0]};
    end else begin
      r.count   = 3'd4;
      r.data[0] = {5'b11110, cp[20:18]};
      r.data[1] = {2'b10, cp[17:12]};
      r.data[2] = {2'b10, cp[11:6]};
      r.data[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end
    return r;
  endfunction

  function automatic step_t normal_step(input logic [7:0] b);
    step_t s;
    s = '{emit: 1'b0, data: 8'h00, done: 1'b0, st: ST_OK, mode: M_NORMAL,
          raw: 2'd0, start_hex: 1'b0};
    if (b == CH_QUOTE) begin
      s.done = 1'b1;
      s.st   = ST_OK;
    end else if (b == CH_NUL) begin
      s.done = 1'b1;
      s.st   = ST_MISSING_QUOTE;
    end else if (b == CH_BSLASH) begin
      s.mode = M_ESCAPE;
    end else if (b < CH_SPACE) begin
      s.done = 1'b1;
      s.st   = ST_BAD_CHAR;
    end else begin
      s.emit = 1'b1;
      s.data = b;
      if ((b & 8'hF8) == 8'hF0) begin
        s.raw = 2'd3;
      end else if ((b & 8'hF0) == 8'hE0) begin
        s.raw = 2'd2;
      end else if ((b & 8'hE0) == 8'hC0) begin
        s.raw = 2'd1;
      end
      s.mode = (s.raw != 2'd0) ? M_RAW : M_NORMAL;
    end
    return s;
  endfunction

  function automatic step_t escape_step(input logic [7:0] b);
    step_t s;
    s = '{emit: 1'b1, data: b, done: 1'b0, st: ST_OK, mode: M_NORMAL,
          raw: 2'd0, start_hex: 1'b0};
    case (b)
      CH_BSLASH, CH_QUOTE, CH_SLASH: s.data = b;
      CH_LC_B: s.data = 8'h08;
      CH_LC_F: s.data = 8'h0C;
      CH_LC_N: s.data = 8'h0A;
      CH_LC_R: s.data = 8'h0D;
      CH_LC_T: s.data = 8'h09;
      CH_LC_U: begin
        s.emit      = 1'b0;
        s.mode      = M_HEX_FIRST;
        s.start_hex = 1'b1;
      end
      default: begin
        s.emit = 1'b0;
        s.done = 1'b1;
        s.st   = ST_BAD_ESCAPE;
      end
    endcase
    return s;
  endfunction

endpackage

### rtl/core/json_string_unescape.sv
// Channel  Direction  Handshake            Payload
// in       receive    in_valid/in_stall    text_byte
// out      send       out_valid/out_stall  out_byte, byte_valid, finished, status, last
//
// Each accepted byte is decoded in the cycle it arrives and its 0..4 results
// land in a result bundle register; they leave one per cycle while out_stall is low, one transfer each.
// A byte with one or no result sustains one byte per cycle while out_stall is low; a byte with n > 1
// results holds the input until its final result is transferred, as there is a single output port.
// Synchronous reset returns the decoder to normal character state and empties
// the bundle. out_stall only holds the bundle; the input is taken again in the
// same cycle the final result of the bundle is transferred.
module json_string_unescape (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        text_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              byte_valid,
  output logic              finished,
  output jsu_pkg::status_t  status,
  output logic              last
);
  import jsu_pkg::*;

  // decoder state
  mode_t       mode, mode_next;
  logic [15:0] code_unit, code_unit_next;
  logic [9:0]  high_half, high_half_next;
  logic [1:0]  digit_count, digit_count_next;
  logic [1:0]  raw_remaining, raw_remaining_next;

  // result bundle: data bytes first, then an optional status result
  logic [3:0][7:0] bnd_data, bnd_data_next;
  logic [2:0]      bnd_nbytes, bnd_nbytes_next;
  logic [2:0]      bnd_total, bnd_total_next;
  status_t         bnd_st, bnd_st_next;
  logic [2:0]      pos;

  logic in_xfer, out_xfer, is_byte;

  // combinational decode helpers
  logic [4:0]  hx;
  logic [15:0] cu_shift;
  logic        pfx_en;        // UTF-8 of a code point goes first
  logic [20:0] pfx_cp;
  logic        tail_en;       // then a normal/escape byte handler
  logic        tail_esc;
  step_t       act;
  logic        byte_en;       // a single plain byte
  logic [7:0]  byte_d;
  logic        fin_en;        // string ends with a status
  status_t     fin_st;
  utf8_t       enc;
  logic [2:0]  pn;

  always_comb begin
    mode_next          = mode;
    code_unit_next     = code_unit;
    high_half_next     = high_half;
    digit_count_next   = digit_count;
    raw_remaining_next = raw_remaining;
    pfx_en   = 1'b0;
    pfx_cp   = '0;
    tail_en  = 1'b0;
    tail_esc = 1'b0;
    byte_en  = 1'b0;
    byte_d   = 8'h00;
    fin_en   = 1'b0;
    fin_st   = ST_OK;
    act      = '0;

    hx       = hex_digit(text_byte);
    cu_shift = {code_unit[11:0], hx[3:0]};

    case (mode)
      M_ESCAPE: begin
        tail_en  = 1'b1;
        tail_esc = 1'b1;
      end
      M_HEX_FIRST: begin
        if (!hx[4]) begin
          fin_en = 1'b1;
          fin_st = ST_BAD_HEX;
        end else begin
          code_unit_next = cu_shift;
          if (digit_count == 2'd3) begin
            digit_count_next = 2'd0;
            if (cu_shift[15:10] == SURR_HI_TAG) begin
              // hold the high half, a low half may follow
              high_half_next = cu_shift[9:0];
              mode_next      = M_AFTER_HIGH;
            end else begin
              pfx_en    = 1'b1;
              pfx_cp    = {5'd0, cu_shift};
              mode_next = M_NORMAL;
            end
          end else begin
            digit_count_next = digit_count + 2'd1;
          end
        end
      end
      M_AFTER_HIGH: begin
        if (text_byte == CH_BSLASH) begin
          mode_next = M_AFTER_HIGH_BS;
        end else begin
          // lone high surrogate goes out as is, then this byte as normal text
          pfx_en  = 1'b1;
          pfx_cp  = {5'd0, SURR_HI_TAG, high_half};
          tail_en = 1'b1;
        end
      end
      M_AFTER_HIGH_BS: begin
        if (text_byte == CH_LC_U) begin
          mode_next        = M_HEX_SECOND;
          code_unit_next   = '0;
          digit_count_next = 2'd0;
        end else begin
          pfx_en   = 1'b1;
          pfx_cp   = {5'd0, SURR_HI_TAG, high_half};
          tail_en  = 1'b1;
          tail_esc = 1'b1;
        end
      end
      M_HEX_SECOND: begin
        if (!hx[4]) begin
          fin_en = 1'b1;
          fin_st = ST_BAD_HEX;
        end else begin
          code_unit_next = cu_shift;
          if (digit_count == 2'd3) begin
            digit_count_next = 2'd0;
            if (cu_shift[15:10] != SURR_LO_TAG) begin
              fin_en = 1'b1;
              fin_st = ST_BAD_SURROGATE;
            end else begin
              pfx_en    = 1'b1;
              pfx_cp    = {SURR_PAIR_BASE + {1'b0, high_half}, cu_shift[9:0]};
              mode_next = M_NORMAL;
            end
          end else begin
            digit_count_next = digit_count + 2'd1;
          end
        end
      end
      M_RAW: begin
        // continuation bytes are copied unchecked; only NUL ends the string
        if (text_byte == CH_NUL) begin
          fin_en = 1'b1;
          fin_st = ST_MISSING_QUOTE;
        end else begin
          byte_en            = 1'b1;
          byte_d             = text_byte;
          raw_remaining_next = raw_remaining - 2'd1;
          if (raw_remaining == 2'd1) begin
            mode_next = M_NORMAL;
          end
        end
      end
      default: begin
        tail_en = 1'b1;
      end
    endcase

    if (tail_en) begin
      act                = tail_esc ? escape_step(text_byte) : normal_step(text_byte);
      byte_en            = act.emit;
      byte_d             = act.data;
      fin_en             = act.done;
      fin_st             = act.st;
      mode_next          = act.mode;
      raw_remaining_next = act.raw;
      if (act.start_hex) begin
        code_unit_next   = '0;
        digit_count_next = 2'd0;
      end
    end

    if (fin_en) begin
      mode_next          = M_NORMAL;
      code_unit_next     = '0;
      high_half_next     = '0;
      digit_count_next   = 2'd0;
      raw_remaining_next = 2'd0;
    end

    // assemble the bundle; a tail byte follows the prefix (which then has
    // at most three bytes)
    enc           = utf8_encode(pfx_cp);
    pn            = pfx_en ? enc.count : 3'd0;
    bnd_data_next = pfx_en ? enc.data : '0;
    if (byte_en) begin
      bnd_data_next[pn[1:0]] = byte_d;
    end
    bnd_nbytes_next = pn + {2'd0, byte_en};
    bnd_total_next  = bnd_nbytes_next + {2'd0, fin_en};
    bnd_st_next     = fin_st;
  end

  // output side
  assign out_valid = (pos != bnd_total);
  assign last      = ((pos + 3'd1) == bnd_total);
  assign out_xfer  = out_valid && !out_stall;
  // take a byte when the bundle is empty or its final result leaves now
  assign in_stall  = out_valid && !(last && !out_stall);
  assign in_xfer   = in_valid && !in_stall;

  assign is_byte    = (pos < bnd_nbytes);
  assign out_byte   = is_byte ? bnd_data[pos[1:0]] : 8'h00;
  assign byte_valid = is_byte;
  assign finished   = !is_byte;
  assign status     = is_byte ? ST_OK : bnd_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_NORMAL;
      code_unit     <= '0;
      high_half     <= '0;
      digit_count   <= 2'd0;
      raw_remaining <= 2'd0;
      pos           <= 3'd0;
      bnd_total     <= 3'd0;
    end else if (in_xfer) begin
      mode          <= mode_next;
      code_unit     <= code_unit_next;
      high_half     <= high_half_next;
      digit_count   <= digit_count_next;
      raw_remaining <= raw_remaining_next;
      pos           <= 3'd0;
      bnd_total     <= bnd_total_next;
    end else if (out_xfer) begin
      pos <= pos + 3'd1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      bnd_data   <= bnd_data_next;
      bnd_nbytes <= bnd_nbytes_next;
      bnd_st     <= bnd_st_next;
    end
  end

endmodule
